// ----- sv/tfn_pkg.sv -----
// ----------------------------------------------------------------------------
// tfn_pkg
// types and constants shared by the face normal unit
// ----------------------------------------------------------------------------
package tfn_pkg;

	localparam int SLOT_W           = 12;
	localparam int POS_W            = 24;
	localparam int NRM_W            = 16;
	localparam int EDGE_W           = 25;
	localparam int CRS_W            = 51;
	localparam int MUL_W            = 30;
	localparam int SQ_W             = 62;
	localparam int ROOT_W           = 31;
	localparam int DIV_NW           = 46;
	localparam int DIV_QW           = 15;
	localparam int FRAC_W           = 14;
	localparam int ONE_Q14          = 16384;
	localparam int VERTEX_DEPTH_DEF = 4096;

	localparam logic [1:0] ACT_LOAD = 2'd0;
	localparam logic [1:0] ACT_TRI  = 2'd1;
	localparam logic [1:0] ACT_READ = 2'd2;
	localparam logic [1:0] ACT_NONE = 2'd3;

	typedef struct packed {
		logic [1:0]               action;
		logic [SLOT_W-1:0]        vertex_slot;
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic signed [POS_W-1:0]  pos_z;
		logic [SLOT_W-1:0]        corner_a;
		logic [SLOT_W-1:0]        corner_b;
		logic [SLOT_W-1:0]        corner_c;
	} in_t;

	typedef struct packed {
		logic signed [NRM_W-1:0]  norm_x;
		logic signed [NRM_W-1:0]  norm_y;
		logic signed [NRM_W-1:0]  norm_z;
		logic                     degenerate;
	} out_t;

endpackage

// ----- sv/tfn_ram.sv -----
// ----------------------------------------------------------------------------
// tfn_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module tfn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

// ----- sv/tfn_mul.sv -----
// ----------------------------------------------------------------------------
// tfn_mul
// bit-serial unsigned shift-add multiplier, one multiplier bit per cycle
// ----------------------------------------------------------------------------
module tfn_mul #(
	parameter int W = 30
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [W-1:0]   a,
	input  logic [W-1:0]   b,
	output logic           done,
	output logic [2*W-1:0] prod
);

	logic                   busy_q;
	logic                   done_q;
	logic [$clog2(W)-1:0]   cnt_q;
	logic [W-1:0]           a_q;
	logic [2*W-1:0]         acc_q;
	logic [W:0]             sum;

	// add the multiplicand into the top half when the current bit is set
	assign sum = {1'b0, acc_q[2*W-1:W]} + (acc_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ($clog2(W))'(W-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			acc_q <= {{W{1'b0}}, b};
		end else if (busy_q) begin
			acc_q <= {sum, acc_q[W-1:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

// ----- sv/tfn_sqrt.sv -----
// ----------------------------------------------------------------------------
// tfn_sqrt
// digit-by-digit floor square root, two radicand bits per cycle
// ----------------------------------------------------------------------------
module tfn_sqrt #(
	parameter int W = 62
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [W-1:0]     x,
	output logic             done,
	output logic [W/2-1:0]   root
);

	logic           busy_q;
	logic           done_q;
	logic [W-1:0]   rem_q;
	logic [W:0]     root_q;
	logic [W-1:0]   bit_q;
	logic [W+1:0]   trial;
	logic           ge;

	assign trial = (W+2)'(root_q) + (W+2)'(bit_q);
	assign ge    = (W+2)'(rem_q) >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= x;
			root_q <= '0;
			bit_q  <= W'(1) << (W-2);
		end else if (busy_q) begin
			if (ge) begin
				rem_q  <= rem_q - trial[W-1:0];
				root_q <= (root_q >> 1) + (W+1)'(bit_q);
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = root_q[W/2-1:0];

endmodule

// ----- sv/tfn_div.sv -----
// ----------------------------------------------------------------------------
// tfn_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tfn_div #(
	parameter int NW = 46,
	parameter int DW = 31,
	parameter int QW = 15
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [QW-1:0] quo
);

	logic                  busy_q;
	logic                  done_q;
	logic [$clog2(QW)-1:0] cnt_q;
	logic [NW-1:0]         rem_q;
	logic [NW-1:0]         dsh_q;
	logic [QW-1:0]         quo_q;
	logic                  ge;

	assign ge = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ($clog2(QW))'(QW-1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			dsh_q <= NW'(den) << (QW-1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			quo_q <= {quo_q[QW-2:0], ge};
			dsh_q <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ----- sv/triangle_face_normal_scatter_top.sv -----
// ----------------------------------------------------------------------------
// triangle_face_normal_scatter_top
// flat face normal unit with per-vertex normal scatter
// ----------------------------------------------------------------------------
// A load request writes one vertex position as it is taken. A read request
// passes through S_NRD0 and S_NRD1 to S_OUT and returns the stored normal of
// the vertex. A triangle request runs through the bit-serial multiplier (six
// cross-product terms and three squares), the normalising shift, the square
// root and three 15-step divisions; the normal is then written to the three
// corners. After reset the normal store is cleared one entry per cycle, and
// no request is taken until the clearing is done. A degenerate triangle
// yields a zero normal with the degenerate flag set. Requests are handled
// one at a time; a finished result waits in an output register while the
// next request is taken.
// ----------------------------------------------------------------------------
module triangle_face_normal_scatter_top #(
	parameter int VERTEX_DEPTH = tfn_pkg::VERTEX_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  tfn_pkg::in_t in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output tfn_pkg::out_t out_data
);

	import tfn_pkg::*;

	localparam int AW = $clog2(VERTEX_DEPTH);
	localparam int XW = (AW > SLOT_W) ? AW : SLOT_W;

	localparam logic [4:0] S_CLR   = 5'd0;
	localparam logic [4:0] S_IDLE  = 5'd1;
	localparam logic [4:0] S_NRD0  = 5'd2;
	localparam logic [4:0] S_NRD1  = 5'd3;
	localparam logic [4:0] S_RA    = 5'd4;
	localparam logic [4:0] S_RB    = 5'd5;
	localparam logic [4:0] S_RC    = 5'd6;
	localparam logic [4:0] S_EDGE  = 5'd7;
	localparam logic [4:0] S_MUL   = 5'd8;
	localparam logic [4:0] S_MULW  = 5'd9;
	localparam logic [4:0] S_NORM  = 5'd10;
	localparam logic [4:0] S_SQ    = 5'd11;
	localparam logic [4:0] S_SQW   = 5'd12;
	localparam logic [4:0] S_SQRT  = 5'd13;
	localparam logic [4:0] S_SQRTW = 5'd14;
	localparam logic [4:0] S_DIV   = 5'd15;
	localparam logic [4:0] S_DIVW  = 5'd16;
	localparam logic [4:0] S_WR    = 5'd17;
	localparam logic [4:0] S_OUT   = 5'd18;

	function automatic logic [AW-1:0] slot_addr(input logic [SLOT_W-1:0] s);
		logic [XW-1:0] e;
		e = XW'(s);
		return e[AW-1:0];
	endfunction

	function automatic logic slot_ok(input logic [SLOT_W-1:0] s);
		return 32'(s) < 32'(VERTEX_DEPTH);
	endfunction

	logic [4:0]               state_q;
	logic [AW-1:0]            clr_q;
	logic [2:0]               k_q;
	logic [SLOT_W-1:0]        slot_q;
	logic [SLOT_W-1:0]        ia_q, ib_q, ic_q;
	logic [3*POS_W-1:0]       pa_q, pb_q;
	logic signed [EDGE_W-1:0] u_q [3];
	logic signed [EDGE_W-1:0] v_q [3];
	logic signed [CRS_W-1:0]  c_q [3];
	logic [CRS_W-1:0]         m_q [3];
	logic                     neg_q;
	logic [SQ_W-1:0]          sum_q;
	logic [ROOT_W-1:0]        len_q;
	logic signed [NRM_W-1:0]  n_q [3];
	logic                     degen_q;
	logic                     out_valid_q;
	out_t                     out_q;

	// ram ports
	logic                     pos_we;
	logic [AW-1:0]            pos_rd_addr;
	logic [3*POS_W-1:0]       pos_rd_data;
	logic [3*POS_W-1:0]       pos_val;
	logic                     nrm_we;
	logic [AW-1:0]            nrm_wr_addr;
	logic [3*NRM_W-1:0]       nrm_wr_data;
	logic [3*NRM_W-1:0]       nrm_rd_data;
	logic [SLOT_W-1:0]        wr_slot;

	// arithmetic units
	logic                     mul_start, mul_done;
	logic [MUL_W-1:0]         mul_a, mul_b;
	logic [2*MUL_W-1:0]       mul_prod;
	logic                     sqrt_start, sqrt_done;
	logic [ROOT_W-1:0]        sqrt_root;
	logic                     div_start, div_done;
	logic [DIV_NW-1:0]        div_num;
	logic [DIV_QW-1:0]        div_quo;

	logic signed [EDGE_W-1:0] op_a, op_b;
	logic [EDGE_W-1:0]        mag_a, mag_b;
	logic signed [CRS_W-1:0]  sprod;
	logic                     big, tiny;
	logic [DIV_QW-1:0]        qcl;
	logic                     accept;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);

	assign pos_we = accept && (in_data.action == ACT_LOAD) && slot_ok(in_data.vertex_slot);

	always_comb begin
		case (state_q)
			S_RA:    pos_rd_addr = slot_addr(ia_q);
			S_RB:    pos_rd_addr = slot_addr(ib_q);
			default: pos_rd_addr = slot_addr(ic_q);
		endcase
	end

	always_comb begin
		case (k_q)
			3'd0:    wr_slot = ia_q;
			3'd1:    wr_slot = ib_q;
			default: wr_slot = ic_q;
		endcase
	end

	assign nrm_we      = (state_q == S_CLR) || ((state_q == S_WR) && slot_ok(wr_slot));
	assign nrm_wr_addr = (state_q == S_CLR) ? clr_q : slot_addr(wr_slot);
	assign nrm_wr_data = (state_q == S_CLR) ? '0 : {n_q[0], n_q[1], n_q[2]};

	tfn_ram #(.WIDTH(3*POS_W), .DEPTH(VERTEX_DEPTH)) u_pos_ram (
		.clk     (clk),
		.we      (pos_we),
		.wr_addr (slot_addr(in_data.vertex_slot)),
		.wr_data ({in_data.pos_x, in_data.pos_y, in_data.pos_z}),
		.rd_addr (pos_rd_addr),
		.rd_data (pos_rd_data)
	);

	tfn_ram #(.WIDTH(3*NRM_W), .DEPTH(VERTEX_DEPTH)) u_nrm_ram (
		.clk     (clk),
		.we      (nrm_we),
		.wr_addr (nrm_wr_addr),
		.wr_data (nrm_wr_data),
		.rd_addr (slot_addr(slot_q)),
		.rd_data (nrm_rd_data)
	);

	// cross product terms: c0 = u1 v2 - u2 v1, c1 = u2 v0 - u0 v2, c2 = u0 v1 - u1 v0
	always_comb begin
		case (k_q)
			3'd0:    begin op_a = u_q[1]; op_b = v_q[2]; end
			3'd1:    begin op_a = u_q[2]; op_b = v_q[1]; end
			3'd2:    begin op_a = u_q[2]; op_b = v_q[0]; end
			3'd3:    begin op_a = u_q[0]; op_b = v_q[2]; end
			3'd4:    begin op_a = u_q[0]; op_b = v_q[1]; end
			default: begin op_a = u_q[1]; op_b = v_q[0]; end
		endcase
	end

	assign mag_a = op_a[EDGE_W-1] ? EDGE_W'(-op_a) : EDGE_W'(op_a);
	assign mag_b = op_b[EDGE_W-1] ? EDGE_W'(-op_b) : EDGE_W'(op_b);

	always_comb begin
		if (state_q == S_SQ) begin
			case (k_q)
				3'd0:    mul_a = m_q[0][MUL_W-1:0];
				3'd1:    mul_a = m_q[1][MUL_W-1:0];
				default: mul_a = m_q[2][MUL_W-1:0];
			endcase
			mul_b = mul_a;
		end else begin
			mul_a = MUL_W'(mag_a);
			mul_b = MUL_W'(mag_b);
		end
	end

	assign mul_start = (state_q == S_MUL) || (state_q == S_SQ);
	assign sprod     = neg_q ? -CRS_W'(mul_prod) : CRS_W'(mul_prod);

	tfn_mul #(.W(MUL_W)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	assign sqrt_start = (state_q == S_SQRT);

	tfn_sqrt #(.W(SQ_W)) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sqrt_start),
		.x      (sum_q),
		.done   (sqrt_done),
		.root   (sqrt_root)
	);

	always_comb begin
		case (k_q)
			3'd0:    div_num = {m_q[0][MUL_W-1:0], {FRAC_W{1'b0}}};
			3'd1:    div_num = {m_q[1][MUL_W-1:0], {FRAC_W{1'b0}}};
			default: div_num = {m_q[2][MUL_W-1:0], {FRAC_W{1'b0}}};
		endcase
		div_num = div_num + DIV_NW'(len_q >> 1);
	end

	assign div_start = (state_q == S_DIV);

	tfn_div #(.NW(DIV_NW), .DW(ROOT_W), .QW(DIV_QW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (len_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign qcl = (div_quo > DIV_QW'(ONE_Q14)) ? DIV_QW'(ONE_Q14) : div_quo;

	// largest magnitude above or below the [2^29, 2^30) window
	assign big  = (m_q[0][CRS_W-1:MUL_W] != '0) || (m_q[1][CRS_W-1:MUL_W] != '0)
		|| (m_q[2][CRS_W-1:MUL_W] != '0);
	assign tiny = (m_q[0][CRS_W-1:MUL_W-1] == '0) && (m_q[1][CRS_W-1:MUL_W-1] == '0)
		&& (m_q[2][CRS_W-1:MUL_W-1] == '0);

	// corner with an out-of-range index reads as the origin
	always_comb begin
		case (state_q)
			S_RB:    pos_val = slot_ok(ia_q) ? pos_rd_data : '0;
			S_RC:    pos_val = slot_ok(ib_q) ? pos_rd_data : '0;
			default: pos_val = slot_ok(ic_q) ? pos_rd_data : '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(VERTEX_DEPTH-1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					k_q <= '0;
					if (accept) begin
						case (in_data.action)
							ACT_READ: state_q <= S_NRD0;
							ACT_TRI:  state_q <= S_RA;
							default:  state_q <= S_IDLE;
						endcase
					end
				end
				S_NRD0:  state_q <= S_NRD1;
				S_NRD1:  state_q <= S_OUT;
				S_RA:    state_q <= S_RB;
				S_RB:    state_q <= S_RC;
				S_RC:    state_q <= S_EDGE;
				S_EDGE:  state_q <= S_MUL;
				S_MUL:   state_q <= S_MULW;
				S_MULW: begin
					if (mul_done) begin
						if (k_q == 3'd5) begin
							k_q     <= '0;
							state_q <= S_NORM;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_MUL;
						end
					end
				end
				S_NORM: begin
					if (degen_q) begin
						state_q <= S_WR;
					end else if (!big && !tiny) begin
						state_q <= S_SQ;
					end
				end
				S_SQ:    state_q <= S_SQW;
				S_SQW: begin
					if (mul_done) begin
						if (k_q == 3'd2) begin
							k_q     <= '0;
							state_q <= S_SQRT;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_SQ;
						end
					end
				end
				S_SQRT:  state_q <= S_SQRTW;
				S_SQRTW: begin
					if (sqrt_done) begin
						state_q <= S_DIV;
					end
				end
				S_DIV:   state_q <= S_DIVW;
				S_DIVW: begin
					if (div_done) begin
						if (k_q == 3'd2) begin
							k_q     <= '0;
							state_q <= S_WR;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_DIV;
						end
					end
				end
				S_WR: begin
					if (k_q == 3'd2) begin
						k_q     <= '0;
						state_q <= S_OUT;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				slot_q  <= in_data.vertex_slot;
				ia_q    <= in_data.corner_a;
				ib_q    <= in_data.corner_b;
				ic_q    <= in_data.corner_c;
				degen_q <= 1'b0;
				sum_q   <= '0;
			end
			S_NRD1: begin
				if (slot_ok(slot_q)) begin
					{n_q[0], n_q[1], n_q[2]} <= nrm_rd_data;
				end else begin
					n_q[0] <= '0;
					n_q[1] <= '0;
					n_q[2] <= '0;
				end
			end
			S_RB: pa_q <= pos_val;
			S_RC: pb_q <= pos_val;
			S_EDGE: begin
				u_q[0] <= EDGE_W'($signed(pb_q[3*POS_W-1:2*POS_W]))
					- EDGE_W'($signed(pa_q[3*POS_W-1:2*POS_W]));
				u_q[1] <= EDGE_W'($signed(pb_q[2*POS_W-1:POS_W]))
					- EDGE_W'($signed(pa_q[2*POS_W-1:POS_W]));
				u_q[2] <= EDGE_W'($signed(pb_q[POS_W-1:0]))
					- EDGE_W'($signed(pa_q[POS_W-1:0]));
				v_q[0] <= EDGE_W'($signed(pos_val[3*POS_W-1:2*POS_W]))
					- EDGE_W'($signed(pa_q[3*POS_W-1:2*POS_W]));
				v_q[1] <= EDGE_W'($signed(pos_val[2*POS_W-1:POS_W]))
					- EDGE_W'($signed(pa_q[2*POS_W-1:POS_W]));
				v_q[2] <= EDGE_W'($signed(pos_val[POS_W-1:0]))
					- EDGE_W'($signed(pa_q[POS_W-1:0]));
			end
			S_MUL: neg_q <= op_a[EDGE_W-1] ^ op_b[EDGE_W-1];
			S_MULW: begin
				if (mul_done) begin
					case (k_q)
						3'd0:    c_q[0] <= sprod;
						3'd1:    c_q[0] <= c_q[0] - sprod;
						3'd2:    c_q[1] <= sprod;
						3'd3:    c_q[1] <= c_q[1] - sprod;
						3'd4:    c_q[2] <= sprod;
						default: c_q[2] <= c_q[2] - sprod;
					endcase
				end
			end
			S_NORM: begin
				if (degen_q) begin
					n_q[0] <= '0;
					n_q[1] <= '0;
					n_q[2] <= '0;
				end else if (big) begin
					m_q[0] <= m_q[0] >> 1;
					m_q[1] <= m_q[1] >> 1;
					m_q[2] <= m_q[2] >> 1;
				end else if (tiny) begin
					m_q[0] <= m_q[0] << 1;
					m_q[1] <= m_q[1] << 1;
					m_q[2] <= m_q[2] << 1;
				end
			end
			S_SQW: begin
				if (mul_done) begin
					sum_q <= sum_q + SQ_W'(mul_prod);
				end
			end
			S_SQRTW: begin
				if (sqrt_done) begin
					len_q <= sqrt_root;
				end
			end
			S_DIVW: begin
				if (div_done) begin
					case (k_q)
						3'd0:    n_q[0] <= c_q[0][CRS_W-1] ? -NRM_W'(qcl) : NRM_W'(qcl);
						3'd1:    n_q[1] <= c_q[1][CRS_W-1] ? -NRM_W'(qcl) : NRM_W'(qcl);
						default: n_q[2] <= c_q[2][CRS_W-1] ? -NRM_W'(qcl) : NRM_W'(qcl);
					endcase
				end
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					out_q.norm_x     <= n_q[0];
					out_q.norm_y     <= n_q[1];
					out_q.norm_z     <= n_q[2];
					out_q.degenerate <= degen_q;
				end
			end
			default: ;
		endcase
		// take magnitudes and spot a zero cross product once all terms are in
		if (state_q == S_MULW && mul_done && k_q == 3'd5) begin
			m_q[0] <= c_q[0][CRS_W-1] ? CRS_W'(-c_q[0]) : CRS_W'(c_q[0]);
			m_q[1] <= c_q[1][CRS_W-1] ? CRS_W'(-c_q[1]) : CRS_W'(c_q[1]);
			m_q[2] <= (c_q[2] - sprod) < 0 ? CRS_W'(sprod - c_q[2]) : CRS_W'(c_q[2] - sprod);
			degen_q <= (c_q[0] == '0) && (c_q[1] == '0) && (c_q[2] == sprod);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- tb/triangle_face_normal_scatter_top_test.sv -----
// ----------------------------------------------------------------------------
// triangle_face_normal_scatter_top_test
// drives load, triangle and read requests into the face normal unit, predicts
// each normal with an independent fixed-point model and checks every result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class normal_scoreboard;
	logic signed [23:0] pos_mem [4096][3];
	logic signed [15:0] nrm_mem [4096][3];
	tfn_pkg::out_t      pending [$];
	int                 errors;

	function new();
		errors = 0;
		for (int i = 0; i < 4096; i++)
			for (int k = 0; k < 3; k++) begin
				pos_mem[i][k] = '0;
				nrm_mem[i][k] = '0;
			end
	endfunction

	function longint unsigned int_sqrt(longint unsigned x);
		longint unsigned rem, root, b;
		rem = x;
		root = 0;
		b = 64'd1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (rem >= root + b) begin
				rem -= root + b;
				root = (root >> 1) + b;
			end else begin
				root >>= 1;
			end
			b >>= 2;
		end
		return root;
	endfunction

	function void note_request(tfn_pkg::in_t r);
		tfn_pkg::out_t o;
		longint pa[3], pb[3], pc[3], u[3], v[3], c[3];
		longint unsigned mag[3], mx, sum, len, q;
		logic signed [15:0] n[3];
		logic [11:0] corners[3];
		o = '0;
		mx = 0;
		sum = 0;
		if (r.action == tfn_pkg::ACT_LOAD) begin
			pos_mem[r.vertex_slot][0] = r.pos_x;
			pos_mem[r.vertex_slot][1] = r.pos_y;
			pos_mem[r.vertex_slot][2] = r.pos_z;
		end else if (r.action == tfn_pkg::ACT_READ) begin
			o.norm_x = nrm_mem[r.vertex_slot][0];
			o.norm_y = nrm_mem[r.vertex_slot][1];
			o.norm_z = nrm_mem[r.vertex_slot][2];
			pending = {pending, o};
		end else if (r.action == tfn_pkg::ACT_TRI) begin
			corners[0] = r.corner_a;
			corners[1] = r.corner_b;
			corners[2] = r.corner_c;
			for (int k = 0; k < 3; k++) begin
				pa[k] = pos_mem[r.corner_a][k];
				pb[k] = pos_mem[r.corner_b][k];
				pc[k] = pos_mem[r.corner_c][k];
				u[k] = pb[k] - pa[k];
				v[k] = pc[k] - pa[k];
				n[k] = '0;
			end
			c[0] = u[1] * v[2] - u[2] * v[1];
			c[1] = u[2] * v[0] - u[0] * v[2];
			c[2] = u[0] * v[1] - u[1] * v[0];
			for (int k = 0; k < 3; k++) begin
				mag[k] = c[k] < 0 ? -c[k] : c[k];
				if (mag[k] > mx)
					mx = mag[k];
			end
			if (mx == 0) begin
				o.degenerate = 1'b1;
			end else begin
				while (mx >= (64'd1 << 30)) begin
					mx >>= 1;
					for (int k = 0; k < 3; k++)
						mag[k] >>= 1;
				end
				while (mx < (64'd1 << 29)) begin
					mx <<= 1;
					for (int k = 0; k < 3; k++)
						mag[k] <<= 1;
				end
				for (int k = 0; k < 3; k++)
					sum += mag[k] * mag[k];
				len = int_sqrt(sum);
				for (int k = 0; k < 3; k++) begin
					q = (mag[k] * 16384 + (len >> 1)) / len;
					if (q > 16384)
						q = 16384;
					n[k] = c[k] < 0 ? -16'(q) : 16'(q);
				end
			end
			for (int j = 0; j < 3; j++)
				for (int k = 0; k < 3; k++)
					nrm_mem[corners[j]][k] = n[k];
			o.norm_x = n[0];
			o.norm_y = n[1];
			o.norm_z = n[2];
			pending = {pending, o};
		end
	endfunction

	task report(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	task check_result(tfn_pkg::out_t got);
		tfn_pkg::out_t want;
		if (pending.size() == 0) begin
			report("unexpected result", 0, 0);
			return;
		end
		want = pending.pop_front();
		if (got.norm_x !== want.norm_x)
			report("norm_x", got.norm_x, want.norm_x);
		if (got.norm_y !== want.norm_y)
			report("norm_y", got.norm_y, want.norm_y);
		if (got.norm_z !== want.norm_z)
			report("norm_z", got.norm_z, want.norm_z);
		if (got.degenerate !== want.degenerate)
			report("degenerate", got.degenerate, want.degenerate);
	endtask
endclass

module triangle_face_normal_scatter_top_test;
	logic          clk;
	logic          arst_n;
	logic          in_valid;
	logic          in_ready;
	tfn_pkg::in_t  in_data;
	logic          out_valid;
	logic          out_ready;
	tfn_pkg::out_t out_data;

	normal_scoreboard sb;
	int  send_idle_pct;
	int  recv_idle_pct;
	bit  loaded [4096];
	int  loaded_list [$];

	triangle_face_normal_scatter_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// receiver: random stall, results checked at the rising edge
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_data);
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// called at a falling edge; valid stays high into the next request
	task send_request(tfn_pkg::in_t r);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_data  <= r;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_request(r);
		@(negedge clk);
	endtask

	task load_vertex(int slot, logic [23:0] x, logic [23:0] y, logic [23:0] z);
		tfn_pkg::in_t r;
		r = tfn_pkg::in_t'({$urandom, $urandom, $urandom, $urandom});
		r.action = tfn_pkg::ACT_LOAD;
		r.vertex_slot = 12'(slot);
		r.pos_x = x;
		r.pos_y = y;
		r.pos_z = z;
		if (!loaded[slot]) begin
			loaded[slot] = 1'b1;
			loaded_list = {loaded_list, slot};
		end
		send_request(r);
	endtask

	task triangle(int a, int b, int c);
		tfn_pkg::in_t r;
		r = tfn_pkg::in_t'({$urandom, $urandom, $urandom, $urandom});
		r.action = tfn_pkg::ACT_TRI;
		r.corner_a = 12'(a);
		r.corner_b = 12'(b);
		r.corner_c = 12'(c);
		send_request(r);
	endtask

	task read_normal(int slot);
		tfn_pkg::in_t r;
		r = tfn_pkg::in_t'({$urandom, $urandom, $urandom, $urandom});
		r.action = tfn_pkg::ACT_READ;
		r.vertex_slot = 12'(slot);
		send_request(r);
	endtask

	function int pick_loaded();
		return loaded_list[$urandom_range(loaded_list.size() - 1)];
	endfunction

	// coordinates: half small spans, otherwise full range or the extremes
	function logic [23:0] rand_coord();
		case ($urandom_range(3))
			0: return 24'($urandom);
			1: return 24'($signed($urandom_range(8191)) - 4096);
			2: return $urandom_range(1) ? 24'h7fffff : 24'h800000;
			default: return 24'($signed($urandom_range(255)) - 128);
		endcase
	endfunction

	task random_phase(int count);
		int sel;
		tfn_pkg::in_t r;
		for (int i = 0; i < count; i++) begin
			sel = $urandom_range(99);
			if (sel < 30 || loaded_list.size() < 3)
				load_vertex($urandom_range(4095), rand_coord(), rand_coord(), rand_coord());
			else if (sel < 70)
				triangle(pick_loaded(), pick_loaded(), pick_loaded());
			else if (sel < 95)
				read_normal($urandom_range(1) ? pick_loaded() : $urandom_range(4095));
			else begin
				// unknown action, ignored by the block
				r = tfn_pkg::in_t'({$urandom, $urandom, $urandom, $urandom});
				r.action = tfn_pkg::ACT_NONE;
				send_request(r);
				i--;
			end
		end
	endtask

	task drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_ready = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, degenerate cases, reads of cleared store
		read_normal(0);
		read_normal(4095);
		load_vertex(0, 24'h000000, 24'h000000, 24'h000000);
		load_vertex(1, 24'h001000, 24'h000000, 24'h000000);
		load_vertex(2, 24'h000000, 24'h000000, 24'h001000);
		load_vertex(4095, 24'h7fffff, 24'h7fffff, 24'h7fffff);
		load_vertex(4094, 24'h800000, 24'h800000, 24'h800000);
		load_vertex(4093, 24'h7fffff, 24'h800000, 24'h7fffff);
		triangle(0, 1, 2);
		triangle(0, 2, 1);
		read_normal(1);
		triangle(0, 0, 0);
		triangle(0, 1, 1);
		triangle(4094, 0, 4095);
		triangle(4095, 4094, 4093);
		triangle(4094, 4093, 1);
		read_normal(4093);
		load_vertex(3, 24'h800000, 24'h7fffff, 24'h800000);
		triangle(3, 4093, 0);
		triangle(0, 1, 1);
		read_normal(2);
		read_normal(4095);
		drain();

		send_idle_pct = 22;
		recv_idle_pct = 49;
		random_phase(530);
		send_idle_pct = 49;
		recv_idle_pct = 22;
		random_phase(530);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_phase(530);
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("triangle_face_normal_scatter_top_test OK");
		else
			$display("triangle_face_normal_scatter_top_test NOT OK");
		$finish;
	end

	initial begin
		#200000000;
		$display("triangle_face_normal_scatter_top_test NOT OK");
		$finish;
	end
endmodule

// ----- triangle_face_normal_scatter_top.f -----
sv/tfn_pkg.sv
sv/tfn_ram.sv
sv/tfn_mul.sv
sv/tfn_sqrt.sv
sv/tfn_div.sv
sv/triangle_face_normal_scatter_top.sv
tb/triangle_face_normal_scatter_top_test.sv
